FILE: rtl/core/isort_pkg.sv
// ----------------------------------------------------------------------------
// isort_pkg
// Shared types, constants and the ordering function of the insertion sorter.
// ----------------------------------------------------------------------------
package isort_pkg;

    localparam int VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LEFT,
        OP_NEW,
        OP_RIGHT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     cmp_en;
    } cell_ctrl_t;

    function automatic logic goes_before(input value_t a, input value_t b, input logic desc);
        logic res;
        if (desc)
        begin
            res = (a > b);
        end
        else
        begin
            res = (a < b);
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/isort_if.sv
// ----------------------------------------------------------------------------
// isort_if
// Valid/ready channels for input elements and sorted results.
// ----------------------------------------------------------------------------
interface isort_in_if;
    import isort_pkg::*;

    logic   valid;
    logic   ready;
    value_t value;
    logic   last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface isort_out_if;
    import isort_pkg::*;

    logic   valid;
    logic   ready;
    value_t value_res;
    logic   last_res;
    logic   overflow;

    modport source (output valid, output value_res, output last_res, output overflow,
                    input ready);
    modport sink   (input valid, input value_res, input last_res, input overflow,
                    output ready);
endinterface

FILE: rtl/core/insertion_sorter.sv
// Insertion: an element is compared against every cell when it is accepted, then shifted and placed.
// A new element is taken only after the last one is placed; the chain holds up to MAX_ITEMS elements.
// Emit: after the last element is placed, results leave one per cycle while dout.ready allows, head first,
// while no input is taken; each result is registered from the head cell of the chain.
// Reset: asynchronous, active low; empties the chain, clears overflow, selects ascending.
// ----------------------------------------------------------------------------
// insertion_sorter
// Streaming insertion sorter built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
module insertion_sorter
    import isort_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    isort_in_if.sink    din,
    isort_out_if.source dout
);

    state_t state_reg;
    state_t state_next;

    logic   desc_reg;
    value_t val_reg;
    logic   last_reg;
    logic   dropped_reg;
    logic   dropped_next;

    logic   out_valid_reg;
    logic   out_valid_next;
    value_t out_value_reg;
    logic   out_last_reg;
    logic   out_ovf_reg;

    logic [MAX_ITEMS-1:0] occ;
    logic [MAX_ITEMS-1:0] prec;
    logic [MAX_ITEMS-1:0] keep_mask;
    logic [MAX_ITEMS-1:0] suffix_ok;
    logic [MAX_ITEMS-1:0] move;
    value_t               cell_value [MAX_ITEMS];

    logic   in_acc;
    logic   ins_go;
    logic   full;
    logic   pop;
    logic   pop_last;
    value_t bcast;

    assign in_acc    = din.valid && din.ready;
    assign full      = occ[MAX_ITEMS-1];
    assign ins_go    = (state_reg == ST_INSERT) && !full;
    assign pop       = (state_reg == ST_EMIT) && (!out_valid_reg || dout.ready);
    assign pop_last  = pop && !occ[1];
    assign keep_mask = prec | ~occ;
    assign move      = occ & suffix_ok & {MAX_ITEMS{ins_go}};
    assign bcast     = (state_reg == ST_IDLE) ? din.value : val_reg;

    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        cell_ctrl_t ctrl;
        logic       from_left;
        logic       first_free;
        value_t     left_v;
        value_t     right_v;
        logic       right_o;

        if (i == 0)
        begin : g_head
            assign from_left  = 1'b0;
            assign first_free = !occ[0];
            assign left_v     = '0;
        end
        else
        begin : g_body
            assign from_left  = move[i-1];
            assign first_free = !occ[i] && occ[i-1];
            assign left_v     = cell_value[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_tail
            assign right_v = '0;
            assign right_o = 1'b0;
        end
        else
        begin : g_mid
            assign right_v = cell_value[i+1];
            assign right_o = occ[i+1];
        end

        assign suffix_ok[i] = &keep_mask[MAX_ITEMS-1:i];

        always_comb
        begin
            ctrl.op     = OP_HOLD;
            ctrl.cmp_en = in_acc;
            if (ins_go)
            begin
                if (from_left)
                begin
                    ctrl.op = OP_LEFT;
                end
                else if (move[i] || first_free)
                begin
                    ctrl.op = OP_NEW;
                end
            end
            if (pop)
            begin
                ctrl.op = OP_RIGHT;
            end
        end

        isort_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .desc        (desc_reg),
            .new_value   (bcast),
            .left_value  (left_v),
            .right_value (right_v),
            .right_occ   (right_o),
            .value       (cell_value[i]),
            .occ         (occ[i]),
            .prec        (prec[i])
        );
    end

    always_comb
    begin
        state_next   = state_reg;
        dropped_next = dropped_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                if (full)
                begin
                    dropped_next = 1'b1;
                end
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (pop_last)
                begin
                    state_next   = ST_IDLE;
                    dropped_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            desc_reg      <= 1'b0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                desc_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            val_reg  <= din.value;
            last_reg <= din.last;
        end
        if (pop)
        begin
            out_value_reg <= cell_value[0];
            out_last_reg  <= !occ[1];
            out_ovf_reg   <= dropped_reg;
        end
    end

    assign din.ready      = (state_reg == ST_IDLE);
    assign dout.valid     = out_valid_reg;
    assign dout.value_res = out_value_reg;
    assign dout.last_res  = out_last_reg;
    assign dout.overflow  = out_ovf_reg;

endmodule

FILE: rtl/core/isort_cell.sv
// ----------------------------------------------------------------------------
// isort_cell
// One slot of the sorted chain: holds an element, compares it against the
// broadcast value and shifts to or from its neighbors.
// ----------------------------------------------------------------------------
module isort_cell
    import isort_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       desc,
    input  value_t     new_value,
    input  value_t     left_value,
    input  value_t     right_value,
    input  logic       right_occ,
    output value_t     value,
    output logic       occ,
    output logic       prec
);

    value_t value_reg;
    value_t value_next;
    logic   occ_reg;
    logic   occ_next;
    logic   prec_reg;
    logic   prec_next;

    always_comb
    begin
        value_next = value_reg;
        occ_next   = occ_reg;
        prec_next  = prec_reg;
        unique case (ctrl.op)
            OP_HOLD:
            begin
                value_next = value_reg;
            end
            OP_LEFT:
            begin
                value_next = left_value;
                occ_next   = 1'b1;
            end
            OP_NEW:
            begin
                value_next = new_value;
                occ_next   = 1'b1;
            end
            OP_RIGHT:
            begin
                value_next = right_value;
                occ_next   = right_occ;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
        if (ctrl.cmp_en)
        begin
            prec_next = occ_reg && goes_before(new_value, value_reg, desc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= 1'b0;
            prec_reg <= 1'b0;
        end
        else
        begin
            occ_reg  <= occ_next;
            prec_reg <= prec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign occ   = occ_reg;
    assign prec  = prec_reg;

endmodule

FILE: rtl/core/isort_checker.sv
// ----------------------------------------------------------------------------
// isort_checker
// Port-level checks of the insertion sorter, bound to the top level.
// ----------------------------------------------------------------------------
module isort_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_last,
    input logic out_ovf
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped while stalled");

    a_insert_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken during placement cycle");

    a_no_input_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("input ready while a sorted run is being emitted");

    a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && $past(out_valid) && !$past(out_last) |-> out_ovf == $past(out_ovf))
        else $error("overflow flag changed within a run");

endmodule

bind insertion_sorter isort_checker u_isort_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_last  (dout.last_res),
    .out_ovf   (dout.overflow)
);

FILE: sim/insertion_sorter_test.sv
// ----------------------------------------------------------------------------
// insertion_sorter_test
// Self-checking testbench for the streaming insertion sorter. Runs of signed
// values are fed through the input channel, a local predictor keeps its own
// sorted store and overflow flag, and every result transaction is compared
// field by field with the oldest predicted one. Directed runs cover extremes,
// both orders, duplicates, single-element runs, a mid-run order change and
// store overflow; random runs follow under random stalls on both channels.
// ----------------------------------------------------------------------------
module insertion_sorter_test
    import isort_pkg::*;
();

    localparam int STORE_CAP     = 64;
    localparam int ITEM_TARGET   = 370;
    localparam int SETTLE_CYCLES = 8;
    localparam int LIMIT_CYCLES  = 400000;

    localparam logic ORDER_ASCENDING  = 1'b0;
    localparam logic ORDER_DESCENDING = 1'b1;

    localparam value_t VALUE_MIN = 32'sh8000_0000;
    localparam value_t VALUE_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        value_t value_res;
        logic   last_res;
        logic   overflow;
    } sorted_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    isort_in_if  in_ch ();
    isort_out_if out_ch ();

    insertion_sorter #(
        .MAX_ITEMS (STORE_CAP)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .din       (in_ch),
        .dout      (out_ch)
    );

    value_t         model_store [STORE_CAP];
    int             model_fill;
    logic           model_dropped;
    logic           model_desc;
    sorted_result_t pending_results [$];

    int   error_count;
    int   items_sent;
    int   runs_sent;
    int   overflow_runs;
    int   results_checked;
    int   cycle_count;
    int   rx_hold_cycles;
    int   rx_stall_left;
    logic tx_steady;
    logic rx_steady;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic value_t pick_value();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       return VALUE_MIN;
                    1:       return VALUE_MAX;
                    2:       return 32'sd0;
                    3:       return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            1, 2, 3: return $signed($urandom_range(0, 15)) - 32'sd8;
            default: return $urandom;
        endcase
    endfunction

    task automatic predict_item(input value_t v, input logic is_last);
        int             pos;
        sorted_result_t r;
        if (model_fill >= STORE_CAP)
        begin
            model_dropped = 1'b1;
        end
        else
        begin
            pos = model_fill;
            while (pos > 0 &&
                   (model_desc ? (v > model_store[pos-1]) : (v < model_store[pos-1])))
            begin
                model_store[pos] = model_store[pos-1];
                pos--;
            end
            model_store[pos] = v;
            model_fill++;
        end
        if (is_last)
        begin
            for (int i = 0; i < model_fill; i++)
            begin
                r.value_res = model_store[i];
                r.last_res  = (i == model_fill - 1);
                r.overflow  = model_dropped;
                pending_results.push_back(r);
            end
            if (model_dropped)
            begin
                overflow_runs++;
            end
            runs_sent++;
            model_fill    = 0;
            model_dropped = 1'b0;
        end
    endtask

    task automatic send_item(input value_t v, input logic is_last);
        int gap;
        gap = tx_steady ? 0 : gap_len();
        if (gap > 0)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        in_ch.last  <= is_last;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        predict_item(v, is_last);
        items_sent++;
    endtask

    task automatic send_run(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_item(pick_value(), i == len - 1);
        end
    endtask

    task automatic pause_input(input int cycles);
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_order(input logic desc);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= desc;
        @(posedge clk);
        model_desc = desc;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_extremes();
        value_t edge_vals [5];
        edge_vals = '{32'sd0, -32'sd1, VALUE_MAX, VALUE_MIN, 32'sd1};
        write_order(ORDER_ASCENDING);
        foreach (edge_vals[i])
        begin
            send_item(edge_vals[i], i == 4);
        end
        drain_results();
        write_order(ORDER_DESCENDING);
        foreach (edge_vals[i])
        begin
            send_item(edge_vals[i], i == 4);
        end
        drain_results();
    endtask

    task automatic test_duplicates();
        write_order(ORDER_ASCENDING);
        send_item(32'sd5, 1'b0);
        send_item(-32'sd5, 1'b0);
        send_item(32'sd5, 1'b0);
        send_item(VALUE_MIN, 1'b1);
        send_item(VALUE_MAX, 1'b1);
        drain_results();
    endtask

    task automatic test_order_change();
        write_order(ORDER_ASCENDING);
        send_item(32'sd10, 1'b0);
        send_item(-32'sd20, 1'b0);
        send_item(32'sd30, 1'b0);
        pause_input(SETTLE_CYCLES);
        write_order(ORDER_DESCENDING);
        send_item(32'sd0, 1'b0);
        send_item(32'sd40, 1'b1);
        drain_results();
    endtask

    task automatic test_capacity();
        write_order(ORDER_DESCENDING);
        send_run(STORE_CAP);
        drain_results();
        write_order(ORDER_ASCENDING);
        send_run(STORE_CAP + 1);
        drain_results();
    endtask

    task automatic test_backpressure();
        drain_results();
        @(posedge clk);
        rx_hold_cycles = 250;
        tx_steady      = 1'b1;
        send_run(16);
        send_run(16);
        send_run(8);
        tx_steady = 1'b0;
        drain_results();
    endtask

    task automatic test_random();
        int r;
        int len;
        while (items_sent < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                drain_results();
                write_order(($urandom_range(0, 1) == 0) ? ORDER_ASCENDING : ORDER_DESCENDING);
            end
            else if (r < 20)
            begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 85)
            begin
                len = $urandom_range(1, 12);
            end
            else if (r < 96)
            begin
                len = $urandom_range(13, 40);
            end
            else
            begin
                len = $urandom_range(STORE_CAP, STORE_CAP + 6);
            end
            send_run(len);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        drain_results();
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (rx_hold_cycles > 0)
        begin
            out_ch.ready <= 1'b0;
            rx_hold_cycles--;
        end
        else if (rx_steady)
        begin
            out_ch.ready <= 1'b1;
        end
        else if (rx_stall_left > 0)
        begin
            out_ch.ready <= 1'b0;
            rx_stall_left--;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
            begin
                rx_stall_left = gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        sorted_result_t exp_r;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction: value_res %0d", out_ch.value_res);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                results_checked++;
                if (out_ch.value_res !== exp_r.value_res)
                begin
                    $error("value_res: expected %0d, actual %0d",
                           exp_r.value_res, out_ch.value_res);
                    error_count++;
                end
                if (out_ch.last_res !== exp_r.last_res)
                begin
                    $error("last_res: expected %0b, actual %0b",
                           exp_r.last_res, out_ch.last_res);
                    error_count++;
                end
                if (out_ch.overflow !== exp_r.overflow)
                begin
                    $error("overflow: expected %0b, actual %0b",
                           exp_r.overflow, out_ch.overflow);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.value     = '0;
        in_ch.last      = 1'b0;
        model_fill      = 0;
        model_dropped   = 1'b0;
        model_desc      = ORDER_ASCENDING;
        error_count     = 0;
        items_sent      = 0;
        runs_sent       = 0;
        overflow_runs   = 0;
        results_checked = 0;
        rx_hold_cycles  = 0;
        tx_steady       = 1'b0;
        rx_steady       = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_extremes();
        test_duplicates();
        test_order_change();
        test_capacity();
        test_backpressure();
        test_random();

        $display("Sent %0d input transactions in %0d sorted runs, %0d of them overflowing.",
                 items_sent, runs_sent, overflow_runs);
        $display("Checked %0d result transactions in both orders under random stalls.",
                 results_checked);
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
